// ----- rtl/core/bdascii_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdascii_pkg;

  localparam int VALUE_W = 16;
  localparam int BCD_DIGITS = 5;          // enough decimal digits for any 16-bit value
  localparam int MAX_DIGITS = 4;          // largest digit count supported, 2 to 5
  localparam int STEPS_PER_STAGE = 4;     // shift-and-add-3 steps in each stage
  localparam int DD_STAGES = VALUE_W / STEPS_PER_STAGE;
  localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CFG_W = 3;
  localparam int CHAR_W = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);
  localparam logic [CFG_W-1:0] MIN_COUNT = CFG_W'(2);
  localparam logic [CFG_W-1:0] MAX_COUNT = CFG_W'(MAX_DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    bcd_t               bcd;
    logic [VALUE_W-1:0] bin;
  } dd_t;

  // one shift-and-add-3 step: correct every digit, then shift the next binary bit in
  function automatic dd_t dd_step(dd_t d);
    dd_t r;
    r = d;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (r.bcd[i] >= 4'd5) begin
        r.bcd[i] = r.bcd[i] + 4'd3;
      end
    end
    r = r << 1;
    return r;
  endfunction

  function automatic dd_t dd_stage(dd_t d);
    dd_t r;
    r = d;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      r = dd_step(r);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/binary_to_decimal_ascii_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// binary to decimal ascii: each 16-bit word on the value channel comes out as
// its decimal digits in ascii, most significant first, one character per word
// on the output channel, leading zeros dropped (zero gives a single '0').
// digit_count, written through digit_count_we by the user only while the unit is
// idle (the unit does not enforce this), sets how many digits are converted;
// values below 2 act as 2 and values above the supported maximum of four act as
// four. a value that does not fit gives that many '9' characters with overflow
// high on each. last marks the final character of a value. the conversion is a
// four-stage shift-and-add-3 pipeline (four bit steps per stage) feeding a
// character emitter; a taken value passes stage registers 0 to 3, then the
// emitter register. the emitter sends one character per cycle when out_stall
// is low; the pipeline keeps taking values while the emitter is busy, until full.
module binary_to_decimal_ascii_unit
  import bdascii_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                digit_count_we,
  input  wire logic [CFG_W-1:0]    digit_count,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [VALUE_W-1:0]  value,
  // output channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CHAR_W-1:0]        character,
  output logic                     last,
  output logic                     overflow
);

  // configuration register, raw as written
  logic [CFG_W-1:0] digits_cfg;

  // conversion pipeline
  logic [DD_STAGES-1:0] stage_valid;
  dd_t                  stage_data [DD_STAGES];
  logic [DD_STAGES-1:0] stage_ready;

  // character emitter
  logic                        em_valid;
  logic [MAX_DIGITS-1:0][3:0]  em_digits;
  logic [POS_W-1:0]            em_pos;
  logic                        em_ovf;
  logic                        em_ready;

  // load values for the emitter
  logic [CFG_W-1:0] eff_count;
  logic [POS_W-1:0] load_pos;
  logic             load_ovf;
  bcd_t             tail_bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_cfg <= CFG_RESET;
    end else if (digit_count_we) begin
      digits_cfg <= digit_count;
    end
  end

  // a stage moves on when it is empty or the one after it moves on
  assign em_ready = !em_valid || (!out_stall && (em_pos == '0));

  always_comb begin
    stage_ready[DD_STAGES-1] = !stage_valid[DD_STAGES-1] || em_ready;
    for (int i = DD_STAGES - 2; i >= 0; i--) begin
      stage_ready[i] = !stage_valid[i] || stage_ready[i+1];
    end
  end

  assign in_stall = !stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < DD_STAGES; i++) begin
        if (stage_ready[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // payload follows the valid bits, no reset needed
  always_ff @(posedge clk) begin
    if (stage_ready[0]) begin
      stage_data[0] <= dd_stage('{bcd: '0, bin: value});
    end
    for (int i = 1; i < DD_STAGES; i++) begin
      if (stage_ready[i]) begin
        stage_data[i] <= dd_stage(stage_data[i-1]);
      end
    end
  end

  // clamp the configured count into the supported range
  always_comb begin
    eff_count = digits_cfg;
    if (eff_count < MIN_COUNT) begin
      eff_count = MIN_COUNT;
    end
    if (eff_count > MAX_COUNT) begin
      eff_count = MAX_COUNT;
    end
  end

  // overflow when any digit at or above the count is non-zero; otherwise start
  // at the highest non-zero digit below the count (or the units digit for zero)
  always_comb begin
    tail_bcd = stage_data[DD_STAGES-1].bcd;
    load_ovf = 1'b0;
    load_pos = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if ((CFG_W'(i) >= eff_count) && (tail_bcd[i] != 4'd0)) begin
        load_ovf = 1'b1;
      end
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((CFG_W'(i) < eff_count) && (tail_bcd[i] != 4'd0)) begin
        load_pos = POS_W'(i);
      end
    end
    if (load_ovf) begin
      load_pos = POS_W'(eff_count - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
    end else if (em_ready) begin
      em_valid <= stage_valid[DD_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (em_ready) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        em_digits[i] <= tail_bcd[i];
      end
      em_pos <= load_pos;
      em_ovf <= load_ovf;
    end else if (!out_stall) begin
      // current character taken, step down to the next digit
      em_pos <= em_pos - POS_W'(1);
    end
  end

  assign out_valid = em_valid;
  assign character = em_ovf ? ASCII_NINE : (ASCII_ZERO + {2'b00, em_digits[em_pos]});
  assign last      = (em_pos == '0);
  assign overflow  = em_ovf;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// self-checking bench for the binary to decimal ascii unit
module tb_top;
  import bdascii_pkg::*;

  localparam int LIMIT           = 400000;  // cycles before the run is called hung
  localparam int RAND_PHASES     = 6;
  localparam int WORDS_PER_PHASE = 39;
  localparam int DRAIN_CYCLES    = 20;      // pipeline is five deep, leave plenty of slack
  localparam int DIR_N           = 25;

  // one expected character word on the output channel
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              lst;
    logic              ovf;
  } char_word_t;

  // directed row: digit count, value, and where obvious the text it must give
  // (text is packed ascii, right aligned, so "99" sits in the two low bytes)
  typedef struct packed {
    logic [CFG_W-1:0]   cnt;
    logic [VALUE_W-1:0] val;
    logic               typed;
    logic [31:0]        txt;
    logic               ovf;
  } dir_row_t;

  dir_row_t dir_tab [DIR_N] = '{
    // reset count of four
    '{3'd4, 16'd0,     1'b1, 32'("0"),   1'b0},  // zero gives a lone '0'
    '{3'd4, 16'd65535, 1'b1, "9999",     1'b1},  // every value bit set
    '{3'd4, 16'd9999,  1'b1, "9999",     1'b0},  // largest that fits
    '{3'd4, 16'd10000, 1'b1, "9999",     1'b1},  // smallest that saturates
    '{3'd4, 16'd1,     1'b1, 32'("1"),   1'b0},
    '{3'd4, 16'd1000,  1'b1, "1000",     1'b0},  // inner zeros kept
    '{3'd4, 16'd32768, 1'b1, "9999",     1'b1},  // top bit alone
    '{3'd4, 16'd4321,  1'b0, 32'd0,      1'b0},
    '{3'd4, 16'd507,   1'b0, 32'd0,      1'b0},
    // two digits
    '{3'd2, 16'd99,    1'b1, 32'("99"),  1'b0},
    '{3'd2, 16'd100,   1'b1, 32'("99"),  1'b1},
    '{3'd2, 16'd0,     1'b1, 32'("0"),   1'b0},
    '{3'd2, 16'd5,     1'b1, 32'("5"),   1'b0},
    '{3'd2, 16'd65535, 1'b1, 32'("99"),  1'b1},
    // three digits works like the others
    '{3'd3, 16'd999,   1'b1, 32'("999"), 1'b0},
    '{3'd3, 16'd1000,  1'b1, 32'("999"), 1'b1},
    '{3'd3, 16'd250,   1'b0, 32'd0,      1'b0},
    // counts below two act as two
    '{3'd0, 16'd42,    1'b0, 32'd0,      1'b0},
    '{3'd0, 16'd123,   1'b1, 32'("99"),  1'b1},
    '{3'd1, 16'd100,   1'b1, 32'("99"),  1'b1},
    '{3'd1, 16'd9,     1'b1, 32'("9"),   1'b0},
    // counts above the maximum act as the maximum
    '{3'd7, 16'd12345, 1'b1, "9999",     1'b1},
    '{3'd7, 16'd4096,  1'b0, 32'd0,      1'b0},
    '{3'd5, 16'd9999,  1'b1, "9999",     1'b0},
    '{3'd6, 16'd6,     1'b1, 32'("6"),   1'b0}
  };

  // digit counts for the first random phases, extremes included
  logic [CFG_W-1:0] phase_cnt [5] = '{3'd2, 3'd4, 3'd7, 3'd0, 3'd3};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               digit_count_we = 1'b0;
  logic [CFG_W-1:0]   digit_count = CFG_RESET;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  character;
  logic               last;
  logic               overflow;

  char_word_t       expected_chars [$];     // characters still owed by the unit
  logic [CFG_W-1:0] cfg_now = CFG_RESET;    // digit count the unit holds
  int               n_fail = 0;
  int               cycle_cnt = 0;
  int               rx_hold = 0;
  bit               tx_calm = 1'b0;         // sender runs back to back when set

  binary_to_decimal_ascii_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .digit_count_we (digit_count_we),
    .digit_count    (digit_count),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .character      (character),
    .last           (last),
    .overflow       (overflow)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // digit count actually used: clamped to the supported range
  function automatic int eff_count(input logic [CFG_W-1:0] c);
    int n;
    n = int'(c);
    if (n < int'(MIN_COUNT)) n = int'(MIN_COUNT);
    if (n > MAX_DIGITS) n = MAX_DIGITS;
    return n;
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic lst,
                                    input logic ovf);
    char_word_t w;
    w.ch  = ch;
    w.lst = lst;
    w.ovf = ovf;
    expected_chars.push_back(w);
  endfunction

  // queue the text typed into a directed row, most significant byte first
  function automatic void push_typed(input logic [31:0] txt, input logic ovf);
    int len;
    len = 0;
    for (int b = 0; b < 4; b++) begin
      if (txt[b*8 +: 8] != 8'd0) len = b + 1;
    end
    for (int b = len - 1; b >= 0; b--) begin
      push_char(CHAR_W'(txt[b*8 +: 8]), b == 0, ovf);
    end
  endfunction

  // decimal text of one value at digit count c, leading zeros dropped
  function automatic void predict_text(input logic [VALUE_W-1:0] v,
                                       input logic [CFG_W-1:0] c);
    int n;
    int rest;
    int first;
    int dig [MAX_DIGITS];
    n = eff_count(c);
    rest = int'(v);
    if (rest == 0) begin
      push_char(ASCII_ZERO, 1'b1, 1'b0);
    end else if (rest >= 10 ** n) begin
      // does not fit: all nines, overflow on each
      for (int i = 0; i < n; i++) begin
        push_char(ASCII_NINE, i == n - 1, 1'b1);
      end
    end else begin
      // dig[0] is the most significant digit
      for (int i = n - 1; i >= 0; i--) begin
        dig[i] = rest % 10;
        rest = rest / 10;
      end
      first = 0;
      while (first < n - 1 && dig[first] == 0) first++;
      for (int i = first; i < n; i++) begin
        push_char(ASCII_ZERO + CHAR_W'(dig[i]), i == n - 1, 1'b0);
      end
    end
  endfunction

  // mostly in range, with zero, both sides of the saturation edge and wide values
  function automatic logic [VALUE_W-1:0] pick_value(input int n);
    int lim;
    lim = 10 ** n;
    case ($urandom_range(0, 15))
      0: begin
        return '0;
      end
      1: begin
        return VALUE_W'(lim - 1);
      end
      2: begin
        return VALUE_W'(lim);
      end
      3: begin
        return VALUE_W'($urandom_range(0, 65535));
      end
      4: begin
        return VALUE_W'($urandom_range(lim, 65535));
      end
      default: begin
        return VALUE_W'($urandom_range(1, lim - 1));
      end
    endcase
  endfunction

  // idle cycles before a word: mostly none or short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one word and hold it until the unit takes it
  // valid is only dropped when a gap follows, so it never falls and rises in one step
  task automatic send_word(input logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every owed character
  task automatic drain_chars();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // digit count is only changed once the unit has gone quiet
  task automatic set_count(input logic [CFG_W-1:0] c);
    drain_chars();
    @(posedge clk);
    digit_count_we <= 1'b1;
    digit_count    <= c;
    @(posedge clk);
    digit_count_we <= 1'b0;
    cfg_now = c;
  endtask

  // receiver pacing: calm stretches, otherwise random stalls of mixed length
  always @(posedge clk) begin : rx_pace
    logic stall_nxt;
    stall_nxt = 1'b0;
    if (rst || ((cycle_cnt / 600) % 3 == 2)) begin
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      stall_nxt = 1'b1;
      rx_hold--;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_nxt = 1'b1;
      rx_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
    out_stall <= stall_nxt;
  end

  // every accepted character word against the oldest one owed
  always @(posedge clk) begin : char_check
    char_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character word: character %0d last %0b overflow %0b",
               character, last, overflow);
        n_fail++;
      end else begin
        want = expected_chars.pop_front();
        if (character !== want.ch) begin
          $error("character: expected %0d, got %0d", want.ch, character);
          n_fail++;
        end
        if (last !== want.lst) begin
          $error("last: expected %0b, got %0b", want.lst, last);
          n_fail++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, overflow);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $error("no progress after %0d cycles, %0d characters still owed",
             LIMIT, expected_chars.size());
      $display("** binary_to_decimal_ascii_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] v;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: count changes happen between rows once the unit is quiet
    for (int r = 0; r < DIR_N; r++) begin
      if (dir_tab[r].cnt != cfg_now) set_count(dir_tab[r].cnt);
      if (dir_tab[r].typed) begin
        push_typed(dir_tab[r].txt, dir_tab[r].ovf);
      end else begin
        predict_text(dir_tab[r].val, cfg_now);
      end
      send_word(dir_tab[r].val);
    end

    // random phases, each at its own digit count
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_count((p < 5) ? phase_cnt[p] : CFG_W'($urandom_range(0, 7)));
      tx_calm = (p == 2);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        v = pick_value(eff_count(cfg_now));
        predict_text(v, cfg_now);
        send_word(v);
      end
    end

    // let the last characters out, then watch for strays
    drain_chars();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("** binary_to_decimal_ascii_unit: PASSED **");
    end else begin
      $display("** binary_to_decimal_ascii_unit: FAILED **");
    end
    $finish;
  end

endmodule
